// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker modules.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define RFS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define RFS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/rfs_pkg.sv
// Package for the register file with scoreboard and forwarding.
// Operation codes, field widths and the structs passed between modules.
package rfs_pkg;

  localparam int OP_W    = 2;
  localparam int FTAG_W  = 6;
  localparam int FREG_W  = 5;
  localparam int DATA_W  = 64;

  typedef enum logic [OP_W-1:0] {
    OP_ISSUE  = 2'd0,
    OP_RESULT = 2'd1,
    OP_RETIRE = 2'd2,
    OP_FLUSH  = 2'd3
  } op_t;

  // Scoreboard update for one operation, already gated by the transfer.
  typedef struct packed {
    logic claim;
    logic publish;
    logic retire;
    logic flush;
  } sb_cmd_t;

  // Scoreboard view of one source register.
  typedef struct packed {
    logic busy;
    logic ready;
  } sb_look_t;

endpackage

// File: hw/rtl/rfs_req_if.sv
// Request channel: valid/ready handshake with one operation as payload.
// Depends on rfs_pkg for field widths.
interface rfs_req_if import rfs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [FTAG_W-1:0]        instruction_tag;
  logic [FREG_W-1:0]        source_one;
  logic [FREG_W-1:0]        source_two;
  logic [FREG_W-1:0]        destination;
  logic signed [DATA_W-1:0] data_value;

  modport source (output valid, operation, instruction_tag, source_one, source_two,
                  destination, data_value, input ready);
  modport sink (input valid, operation, instruction_tag, source_one, source_two,
                destination, data_value, output ready);
endinterface

// Response channel: valid/ready handshake with stall flag and operands.
interface rfs_rsp_if import rfs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     stall_res;
  logic signed [DATA_W-1:0] first_operand;
  logic signed [DATA_W-1:0] second_operand;

  modport source (output valid, stall_res, first_operand, second_operand, input ready);
  modport sink (input valid, stall_res, first_operand, second_operand, output ready);
endinterface

// File: hw/rtl/rfs_regfile.sv
// Architectural register file: memory with two registered read ports,
// one write port and per-entry valid bits so unwritten registers read 0.
module rfs_regfile import rfs_pkg::*; #(
  parameter int NUM_REGS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [$clog2(NUM_REGS)-1:0] wr_idx,
  input  logic [DATA_W-1:0]           wr_data,
  input  logic                        rd_en,
  input  logic [$clog2(NUM_REGS)-1:0] rd_idx1,
  input  logic [$clog2(NUM_REGS)-1:0] rd_idx2,
  input  logic [$clog2(NUM_REGS)-1:0] x_idx1,
  input  logic [$clog2(NUM_REGS)-1:0] x_idx2,
  output logic [DATA_W-1:0]           value1,
  output logic [DATA_W-1:0]           value2
);

  logic [DATA_W-1:0]   mem [NUM_REGS];
  logic [NUM_REGS-1:0] written;
  logic [DATA_W-1:0]   rdata1;
  logic [DATA_W-1:0]   rdata2;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    // Pass a write of the same edge straight to the read data.
    if (rd_en) begin
      rdata1 <= (wr_en && wr_idx == rd_idx1) ? wr_data : mem[rd_idx1];
      rdata2 <= (wr_en && wr_idx == rd_idx2) ? wr_data : mem[rd_idx2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_idx] <= 1'b1;
    end
  end

  assign value1 = written[x_idx1] ? rdata1 : '0;
  assign value2 = written[x_idx2] ? rdata2 : '0;

endmodule

// File: hw/rtl/rfs_scoreboard.sv
// Scoreboard: producer tag and ready bit per register in flip-flops, and
// forwarded values kept per tag in a memory with two registered read ports.
module rfs_scoreboard import rfs_pkg::*; #(
  parameter int NUM_REGS = 32,
  parameter int TAG_BITS = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  sb_cmd_t                     cmd,
  input  logic [TAG_BITS-1:0]         upd_tag,
  input  logic [$clog2(NUM_REGS)-1:0] upd_idx,
  input  logic [DATA_W-1:0]           upd_data,
  input  logic                        rd_en,
  input  logic [$clog2(NUM_REGS)-1:0] rd_idx1,
  input  logic [$clog2(NUM_REGS)-1:0] rd_idx2,
  input  logic [$clog2(NUM_REGS)-1:0] x_idx1,
  input  logic [$clog2(NUM_REGS)-1:0] x_idx2,
  output sb_look_t                    look1,
  output sb_look_t                    look2,
  output logic [DATA_W-1:0]           value1,
  output logic [DATA_W-1:0]           value2
);

  localparam int TAG_DEPTH = 2 ** TAG_BITS;

  logic [TAG_BITS-1:0] tag      [NUM_REGS];
  logic [TAG_BITS-1:0] tag_next [NUM_REGS];
  logic [NUM_REGS-1:0] rdy;
  logic [NUM_REGS-1:0] rdy_next;
  logic [DATA_W-1:0]   value_mem [TAG_DEPTH];
  logic [TAG_BITS-1:0] raddr1;
  logic [TAG_BITS-1:0] raddr2;

  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      tag_next[i] = tag[i];
      rdy_next[i] = rdy[i];
      if (cmd.flush) begin
        tag_next[i] = '0;
      end
      if (cmd.publish && tag[i] == upd_tag) begin
        rdy_next[i] = 1'b1;
      end
      if (cmd.claim && upd_idx == i[$clog2(NUM_REGS)-1:0]) begin
        tag_next[i] = upd_tag;
        rdy_next[i] = 1'b0;
      end
      // Release only while the retiring tag still owns the entry.
      if (cmd.retire && upd_idx == i[$clog2(NUM_REGS)-1:0] && tag[i] == upd_tag) begin
        tag_next[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        tag[i] <= '0;
      end
      rdy <= '0;
    end else begin
      for (int i = 0; i < NUM_REGS; i++) begin
        tag[i] <= tag_next[i];
      end
      rdy <= rdy_next;
    end
  end

  // Look up the value through the owner the entry will have after this edge.
  assign raddr1 = tag_next[rd_idx1];
  assign raddr2 = tag_next[rd_idx2];

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      value_mem[upd_tag] <= upd_data;
    end
    if (rd_en) begin
      value1 <= (cmd.publish && upd_tag == raddr1) ? upd_data : value_mem[raddr1];
      value2 <= (cmd.publish && upd_tag == raddr2) ? upd_data : value_mem[raddr2];
    end
  end

  assign look1.busy  = tag[x_idx1] != '0;
  assign look1.ready = rdy[x_idx1];
  assign look2.busy  = tag[x_idx2] != '0;
  assign look2.ready = rdy[x_idx2];

endmodule

// File: hw/rtl/register_file_scoreboard_forwarding_top.sv
// Register file with scoreboard and operand forwarding: top level.
// Uses rfs_pkg, rfs_req_if/rfs_rsp_if, rfs_regfile and rfs_scoreboard.
//
// request carries one operation per transfer: issue check, producer result
// ready, retire write or flush of all producer tags. response returns one
// item per request: the stall flag and both source operands (all zero for
// anything but an issue).
// Each request is registered into an execute stage whose memory reads were
// started at the transfer; the scoreboard and register file update when the
// item leaves that stage for the output register, which drives
// response.valid. One request is taken every cycle while response is
// not stalled.
// If response is stalled the output register holds and the execute stage
// fills; request.ready then drops until the response transfer frees a slot.
// rst (synchronous) empties both stages, zeroes every register value and
// clears every producer tag; the block takes a request on the next cycle.
module register_file_scoreboard_forwarding_top import rfs_pkg::*; #(
  parameter int NUM_REGS = 32,
  parameter int TAG_BITS = 6
) (
  input logic       clk,
  input logic       rst,
  rfs_req_if.sink   request,
  rfs_rsp_if.source response
);

  localparam int REG_BITS = $clog2(NUM_REGS);
  localparam int EXT_W    = (REG_BITS > FREG_W) ? REG_BITS : FREG_W;

  logic in_ready, in_fire, x_fire;

  // incoming source indices, clamped to a legal address
  logic [EXT_W-1:0]    in_s1_ext, in_s2_ext;
  logic                in_s1_ok, in_s2_ok;
  logic [REG_BITS-1:0] in_s1_idx, in_s2_idx;

  // execute stage
  logic                x_valid;
  op_t                 x_op;
  logic [TAG_BITS-1:0] x_tag;
  logic [FREG_W-1:0]   x_s1, x_s2, x_rd;
  logic [DATA_W-1:0]   x_data;
  logic [EXT_W-1:0]    x_s1_ext, x_s2_ext, x_rd_ext;
  logic                x_s1_ok, x_s2_ok, x_rd_ok;
  logic [REG_BITS-1:0] x_s1_idx, x_s2_idx, x_rd_idx;
  logic                use1, use2, stall1, stall2, stall;
  logic [DATA_W-1:0]   opnd1, opnd2;

  sb_cmd_t           cmd;
  sb_look_t          look1, look2;
  logic [DATA_W-1:0] reg_val1, reg_val2, fwd_val1, fwd_val2;

  // output register
  logic              out_valid;
  logic              out_stall;
  logic [DATA_W-1:0] out_a, out_b;

  assign in_fire  = request.valid && in_ready;
  assign x_fire   = x_valid && (!out_valid || response.ready);
  assign in_ready = !x_valid || x_fire;
  assign request.ready = in_ready;

  assign in_s1_ext = EXT_W'(request.source_one);
  assign in_s2_ext = EXT_W'(request.source_two);
  assign in_s1_ok  = 32'(request.source_one) < NUM_REGS;
  assign in_s2_ok  = 32'(request.source_two) < NUM_REGS;
  assign in_s1_idx = in_s1_ok ? in_s1_ext[REG_BITS-1:0] : '0;
  assign in_s2_idx = in_s2_ok ? in_s2_ext[REG_BITS-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid <= 1'b0;
    end else if (in_ready) begin
      x_valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_op   <= op_t'(request.operation);
      x_tag  <= TAG_BITS'(request.instruction_tag);
      x_s1   <= request.source_one;
      x_s2   <= request.source_two;
      x_rd   <= request.destination;
      x_data <= request.data_value;
    end
  end

  assign x_s1_ext = EXT_W'(x_s1);
  assign x_s2_ext = EXT_W'(x_s2);
  assign x_rd_ext = EXT_W'(x_rd);
  assign x_s1_ok  = 32'(x_s1) < NUM_REGS;
  assign x_s2_ok  = 32'(x_s2) < NUM_REGS;
  assign x_rd_ok  = 32'(x_rd) < NUM_REGS;
  assign x_s1_idx = x_s1_ok ? x_s1_ext[REG_BITS-1:0] : '0;
  assign x_s2_idx = x_s2_ok ? x_s2_ext[REG_BITS-1:0] : '0;
  assign x_rd_idx = x_rd_ok ? x_rd_ext[REG_BITS-1:0] : '0;

  assign use1   = x_s1_ok && x_s1 != '0;
  assign use2   = x_s2_ok && x_s2 != '0;
  assign stall1 = use1 && look1.busy && !look1.ready;
  assign stall2 = use2 && look2.busy && !look2.ready;
  assign stall  = (x_op == OP_ISSUE) && (stall1 || stall2);

  always_comb begin
    opnd1 = '0;
    opnd2 = '0;
    if (x_op == OP_ISSUE) begin
      if (use1 && !stall1) begin
        opnd1 = look1.busy ? fwd_val1 : reg_val1;
      end
      if (use2 && !stall2) begin
        opnd2 = look2.busy ? fwd_val2 : reg_val2;
      end
    end
  end

  always_comb begin
    cmd = '0;
    unique case (x_op)
      OP_ISSUE:  cmd.claim   = x_fire && !stall && x_rd_ok && x_rd != '0;
      OP_RESULT: cmd.publish = x_fire && x_tag != '0;
      OP_RETIRE: cmd.retire  = x_fire && x_rd_ok;
      OP_FLUSH:  cmd.flush   = x_fire;
      default:   cmd = '0;
    endcase
  end

  rfs_regfile #(
    .NUM_REGS (NUM_REGS)
  ) u_regfile (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd.retire),
    .wr_idx  (x_rd_idx),
    .wr_data (x_data),
    .rd_en   (in_fire),
    .rd_idx1 (in_s1_idx),
    .rd_idx2 (in_s2_idx),
    .x_idx1  (x_s1_idx),
    .x_idx2  (x_s2_idx),
    .value1  (reg_val1),
    .value2  (reg_val2)
  );

  rfs_scoreboard #(
    .NUM_REGS (NUM_REGS),
    .TAG_BITS (TAG_BITS)
  ) u_scoreboard (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .upd_tag  (x_tag),
    .upd_idx  (x_rd_idx),
    .upd_data (x_data),
    .rd_en    (in_fire),
    .rd_idx1  (in_s1_idx),
    .rd_idx2  (in_s2_idx),
    .x_idx1   (x_s1_idx),
    .x_idx2   (x_s2_idx),
    .look1    (look1),
    .look2    (look2),
    .value1   (fwd_val1),
    .value2   (fwd_val2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || response.ready) begin
      out_valid <= x_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (x_fire) begin
      out_stall <= stall;
      out_a     <= opnd1;
      out_b     <= opnd2;
    end
  end

  assign response.valid          = out_valid;
  assign response.stall_res      = out_stall;
  assign response.first_operand  = out_a;
  assign response.second_operand = out_b;

endmodule

// File: hw/rtl/rfs_checker.sv
// Port-level checks for the register file top level, attached by bind.
// Uses the macros in assert_macros.svh.
`include "assert_macros.svh"

module rfs_checker import rfs_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic              rsp_stall,
  input logic [DATA_W-1:0] rsp_a,
  input logic [DATA_W-1:0] rsp_b
);

  // A waiting response stays offered.
  `RFS_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid, "a_rsp_hold failed")
  // A waiting response keeps its payload.
  `RFS_ASSERT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready |=> $stable(rsp_stall) && $stable(rsp_a) && $stable(rsp_b), "a_rsp_stable failed")
  // With the output register empty the block must take a request.
  `RFS_ASSERT(a_req_open, clk, rst, !rsp_valid |-> req_ready, "a_req_open failed")
  // Reset empties the output register.
  `RFS_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !rsp_valid, "a_rst_empty failed")

endmodule

bind register_file_scoreboard_forwarding_top rfs_checker u_rfs_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (request.ready),
  .rsp_valid (response.valid),
  .rsp_ready (response.ready),
  .rsp_stall (response.stall_res),
  .rsp_a     (response.first_operand),
  .rsp_b     (response.second_operand)
);
